@@ hw/rtl/zurd_pkg.sv @@
`default_nettype none
package zurd_pkg;

  // trailer byte codes
  localparam logic [7:0] TRAILER_HALF = 8'd111;
  localparam logic [7:0] TRAILER_FULL = 8'd222;

  // zero run lengths in units
  localparam logic [5:0] LONG_RUN   = 6'd39;
  localparam logic [5:0] SHORT_BASE = 6'd3;
  localparam logic [5:0] MID_BASE   = 6'd7;

  // kind of a code, from its low two bits
  localparam logic [1:0] CODE_SHORT = 2'd0;
  localparam logic [1:0] CODE_PAIR  = 2'd1;
  localparam logic [1:0] CODE_LIT   = 2'd2;
  localparam logic [1:0] CODE_MID   = 2'd3;

  // end status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_BAD_TRAILER = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW    = 2'd2;

  // configuration
  localparam int unsigned  MAX_BYTES_W     = 16;
  localparam logic [15:0]  MAX_BYTES_RST   = 16'hFFFF;
  localparam int unsigned  CFG_ADDR_W      = 3;
  localparam logic [2:0]   REG_MAX_BYTES   = 3'd0;
  localparam int unsigned  COUNT_WIDTH_DEF = 16;

  // job queue between front and back
  localparam int unsigned JOBQ_DEPTH = 4;

  // one job per accepted item that has work to do
  typedef struct packed {
    logic [7:0] code_byte;  // held compressed byte
    logic [1:0] nib_cnt;    // nibbles of code_byte to decode (0, 1 or 2)
    logic       is_end;     // job closes the stream
    logic       is_bad;     // trailer byte was not a valid trailer
  } zurd_job_t;

endpackage
`default_nettype wire

@@ hw/rtl/zero_unit_rle_decompressor_unit.sv @@
// path: a byte that the low nibble of a released code byte completes at once passes the job
//   queue, the back end's job registers and the output register, as does the end result of a
//   bare trailer by way of the flush and finish states; both wait while the back end is busy
// pace: each job is dispatched, then literal and pair lead units are packed one at a time, a
//   literal pair as two units, a zero run in steps of up to one output byte each; the single
//   unit packer in the back end sets the pace of data transfers
// reset: rst_n synchronous, clears stream state and the job queue, max_output_bytes to 65535
`default_nettype none
module zero_unit_rle_decompressor_unit
  import zurd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] in_byte
  input  wire logic                  in_tlast,   // is_trailer
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] out_byte
  output logic [2:0]                 out_tuser,  // [0] byte_valid, [2:1] status
  output logic                       out_tlast,  // end_of_stream
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic [MAX_BYTES_W-1:0] max_r, max_nxt;
  zurd_job_t              push_job, head_job;
  logic                   q_push, q_pop, q_empty, q_full;
  logic [7:0]             o_byte;
  logic                   o_bv, o_end;
  logic [1:0]             o_st;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_MAX_BYTES) ? {16'd0, max_r} : 32'd0;

  always_comb begin
    max_nxt = max_r;
    if (psel && penable && pwrite && pready && (paddr == REG_MAX_BYTES)) begin
      max_nxt = pwdata[MAX_BYTES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_BYTES_RST;
    end else begin
      max_r <= max_nxt;
    end
  end

  // front: take transfers, hold one byte, issue jobs
  zurd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  // job queue
  zurd_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: decode codes, pack units, emit results
  zurd_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .max_bytes      (max_r),
    .q_job          (head_job),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (o_byte),
    .out_byte_valid (o_bv),
    .out_end        (o_end),
    .out_status     (o_st)
  );

  assign out_tdata = o_byte;
  assign out_tuser = {o_st, o_bv};
  assign out_tlast = o_end;

  // a result without a byte is always the end of a stream and carries a zero byte
  a_nobyte_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && (out_tdata == 8'd0)))
    else $error("result without byte is not a clean end result");

  // an error status only rides on the end result
  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser[2:1] != STAT_OK)) |-> (out_tlast && !out_tuser[0]))
    else $error("error status outside an end result");

  // no transfer is taken while the job queue is full
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> (!in_tready && !q_push))
    else $error("input taken while job queue full");

endmodule
`default_nettype wire

@@ hw/rtl/zurd_front.sv @@
`default_nettype none
module zurd_front
  import zurd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output logic            q_push,
  output zurd_job_t       q_job
);

  logic       held_v_r, held_v_nxt;
  logic [7:0] held_b_r, held_b_nxt;
  logic       accept;
  logic       trl_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign trl_ok   = (in_byte == TRAILER_HALF) || (in_byte == TRAILER_FULL);

  // classify the item into a job for the back end
  always_comb begin
    q_job.code_byte = held_b_r;
    q_job.is_end    = in_last;
    q_job.is_bad    = in_last && !trl_ok;
    q_job.nib_cnt   = 2'd0;
    if (held_v_r) begin
      if (!in_last) begin
        q_job.nib_cnt = 2'd2;
      end else if (trl_ok) begin
        q_job.nib_cnt = (in_byte == TRAILER_FULL) ? 2'd2 : 2'd1;
      end
    end
    q_push = accept && (in_last || held_v_r);
  end

  // hold one byte back until the next transfer decides its fate
  always_comb begin
    held_v_nxt = held_v_r;
    held_b_nxt = held_b_r;
    if (accept) begin
      held_v_nxt = !in_last;
      held_b_nxt = in_last ? 8'd0 : in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      held_b_r <= 8'd0;
    end else begin
      held_v_r <= held_v_nxt;
      held_b_r <= held_b_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/zurd_jobq.sv @@
`default_nettype none
module zurd_jobq
  import zurd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  zurd_job_t push_job,
  input  wire logic pop,
  output zurd_job_t head_job,
  output logic      empty,
  output logic      full
);

  localparam int unsigned PW = $clog2(JOBQ_DEPTH);

  zurd_job_t       mem [JOBQ_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == (PW+1)'(JOBQ_DEPTH));
  assign head_job = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !full) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/zurd_back.sv @@
`default_nettype none
module zurd_back
  import zurd_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [MAX_BYTES_W-1:0] max_bytes,
  input  zurd_job_t                   q_job,
  input  wire logic                   q_empty,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_byte_valid,
  output logic                        out_end,
  output logic [1:0]                  out_status
);

  localparam int unsigned CMPW = (COUNT_WIDTH > MAX_BYTES_W) ? COUNT_WIDTH : MAX_BYTES_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_NIB    = 6'b000010,
    ST_RUN    = 6'b000100,
    ST_LIT2   = 6'b001000,
    ST_FLUSH  = 6'b010000,
    ST_FINISH = 6'b100000
  } zurd_bst_t;

  zurd_bst_t            state_r, state_nxt;
  logic [7:0]           jbyte_r, jbyte_nxt;
  logic [1:0]           jcnt_r, jcnt_nxt;
  logic                 jidx_r, jidx_nxt;
  logic                 jend_r, jend_nxt;
  logic                 jbad_r, jbad_nxt;
  logic [1:0]           slot_r, slot_nxt;
  logic [7:0]           part_r, part_nxt;
  logic                 pend_r, pend_nxt;
  logic [1:0]           lead_r, lead_nxt;
  logic [5:0]           run_r, run_nxt;
  logic [1:0]           lit_r, lit_nxt;
  logic [COUNT_WIDTH-1:0] bcnt_r, bcnt_nxt;
  logic                 fail_r, fail_nxt;
  logic                 stg_v_r, stg_v_nxt;
  logic [7:0]           stg_b_r, stg_b_nxt;
  logic                 ov_r;
  logic [7:0]           ob_r;
  logic                 obv_r, oend_r;
  logic [1:0]           ost_r;

  logic       out_load;
  logic [7:0] ld_byte;
  logic       ld_bv, ld_end;
  logic [1:0] ld_st;
  logic       can_out;

  logic [3:0] nib;
  logic [1:0] v0, v1;
  logic       is_long;
  logic       unit_en, run_en, flush_en;
  logic [1:0] unit_val;
  logic [2:0] room, run_k;
  logic [7:0] unit_part, cmpl_byte;
  logic       cmpl, under_max, emit_req, fail_set, path_ok, stall;
  zurd_bst_t  after_nib;

  assign can_out = !ov_r || out_ready;

  // current code nibble
  assign nib     = jidx_r ? jbyte_r[7:4] : jbyte_r[3:0];
  assign v0      = nib[1:0];
  assign v1      = nib[3:2];
  assign is_long = pend_r && (lead_r == 2'd0) && (nib == 4'd0);

  // unit packing request for this cycle
  always_comb begin
    unit_en  = 1'b0;
    unit_val = v1;
    if (state_r == ST_NIB) begin
      if (pend_r) begin
        unit_en  = !is_long;
        unit_val = v0;
      end else begin
        unit_en = (v0 == CODE_PAIR) || (v0 == CODE_LIT);
      end
    end else if (state_r == ST_LIT2) begin
      unit_en  = 1'b1;
      unit_val = lit_r;
    end
    run_en   = (state_r == ST_RUN);
    flush_en = (state_r == ST_FLUSH) && (slot_r != 2'd0);
  end

  // byte completion and overflow check
  always_comb begin
    room      = 3'd4 - {1'b0, slot_r};
    run_k     = (run_r < {3'b000, room}) ? run_r[2:0] : room;
    unit_part = part_r | ({6'b0, unit_val} << {slot_r, 1'b0});
    cmpl      = (unit_en && (slot_r == 2'd3))
             || (run_en && (({1'b0, slot_r} + run_k) == 3'd4))
             || flush_en;
    cmpl_byte = unit_en ? unit_part : part_r;
    under_max = CMPW'(bcnt_r) < CMPW'(max_bytes);
    emit_req  = cmpl && !fail_r && under_max;
    fail_set  = cmpl && !fail_r && !under_max;
    path_ok   = jend_r ? (!stg_v_r || can_out) : can_out;
    stall     = emit_req && !path_ok;
    after_nib = (!jidx_r && (jcnt_r == 2'd2)) ? ST_NIB : (jend_r ? ST_FLUSH : ST_IDLE);
  end

  // sequencer, packer and result routing
  always_comb begin
    state_nxt = state_r;
    jbyte_nxt = jbyte_r;
    jcnt_nxt  = jcnt_r;
    jidx_nxt  = jidx_r;
    jend_nxt  = jend_r;
    jbad_nxt  = jbad_r;
    slot_nxt  = slot_r;
    part_nxt  = part_r;
    pend_nxt  = pend_r;
    lead_nxt  = lead_r;
    run_nxt   = run_r;
    lit_nxt   = lit_r;
    bcnt_nxt  = bcnt_r;
    fail_nxt  = fail_r;
    stg_v_nxt = stg_v_r;
    stg_b_nxt = stg_b_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    ld_byte   = 8'd0;
    ld_bv     = 1'b0;
    ld_end    = 1'b0;
    ld_st     = STAT_OK;

    // packing of units into the partial byte
    if (!stall) begin
      if (unit_en) begin
        part_nxt = cmpl ? 8'd0 : unit_part;
        slot_nxt = slot_r + 2'd1;
      end else if (run_en) begin
        part_nxt = cmpl ? 8'd0 : part_r;
        slot_nxt = slot_r + run_k[1:0];
        run_nxt  = run_r - {3'b000, run_k};
      end else if (flush_en) begin
        part_nxt = 8'd0;
        slot_nxt = 2'd0;
      end
      if (fail_set) begin
        fail_nxt = 1'b1;
      end
      // completed byte goes out, or waits in the stage during a trailer job
      if (emit_req) begin
        bcnt_nxt = bcnt_r + COUNT_WIDTH'(1);
        if (jend_r) begin
          if (stg_v_r) begin
            out_load = 1'b1;
            ld_byte  = stg_b_r;
            ld_bv    = 1'b1;
          end
          stg_v_nxt = 1'b1;
          stg_b_nxt = cmpl_byte;
        end else begin
          out_load = 1'b1;
          ld_byte  = cmpl_byte;
          ld_bv    = 1'b1;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          jbyte_nxt = q_job.code_byte;
          jcnt_nxt  = q_job.nib_cnt;
          jend_nxt  = q_job.is_end;
          jbad_nxt  = q_job.is_bad;
          jidx_nxt  = 1'b0;
          if (q_job.is_bad) begin
            state_nxt = ST_FINISH;
          end else if (q_job.nib_cnt != 2'd0) begin
            state_nxt = ST_NIB;
          end else if (q_job.is_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_NIB: begin
        if (!stall) begin
          if (pend_r) begin
            pend_nxt = 1'b0;
            if (is_long) begin
              run_nxt   = LONG_RUN;
              state_nxt = ST_RUN;
            end else begin
              lit_nxt   = v1;
              state_nxt = ST_LIT2;
            end
          end else begin
            unique case (v0)
              CODE_SHORT: begin
                run_nxt   = SHORT_BASE + {4'b0000, v1};
                state_nxt = ST_RUN;
              end
              CODE_MID: begin
                run_nxt   = MID_BASE + {4'b0000, v1};
                state_nxt = ST_RUN;
              end
              CODE_PAIR: begin
                pend_nxt  = 1'b1;
                lead_nxt  = v1;
                jidx_nxt  = 1'b1;
                state_nxt = after_nib;
              end
              default: begin
                jidx_nxt  = 1'b1;
                state_nxt = after_nib;
              end
            endcase
          end
        end
      end
      ST_RUN: begin
        if (!stall && (run_r == {3'b000, run_k})) begin
          jidx_nxt  = 1'b1;
          state_nxt = after_nib;
        end
      end
      ST_LIT2: begin
        if (!stall) begin
          jidx_nxt  = 1'b1;
          state_nxt = after_nib;
        end
      end
      ST_FLUSH: begin
        if (!stall) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // end result: last staged byte carries the end mark when all went well
        if (can_out) begin
          out_load = 1'b1;
          if (stg_v_r) begin
            ld_byte   = stg_b_r;
            ld_bv     = 1'b1;
            ld_end    = !fail_r;
            stg_v_nxt = 1'b0;
          end else begin
            ld_end = 1'b1;
            ld_st  = jbad_r ? STAT_BAD_TRAILER : (fail_r ? STAT_OVERFLOW : STAT_OK);
          end
          if (!stg_v_r || !fail_r) begin
            state_nxt = ST_IDLE;
            slot_nxt  = 2'd0;
            part_nxt  = 8'd0;
            pend_nxt  = 1'b0;
            lead_nxt  = 2'd0;
            bcnt_nxt  = '0;
            fail_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      jbyte_r <= 8'd0;
      jcnt_r  <= 2'd0;
      jidx_r  <= 1'b0;
      jend_r  <= 1'b0;
      jbad_r  <= 1'b0;
      slot_r  <= 2'd0;
      part_r  <= 8'd0;
      pend_r  <= 1'b0;
      lead_r  <= 2'd0;
      run_r   <= 6'd0;
      lit_r   <= 2'd0;
      bcnt_r  <= '0;
      fail_r  <= 1'b0;
      stg_v_r <= 1'b0;
      stg_b_r <= 8'd0;
    end else begin
      state_r <= state_nxt;
      jbyte_r <= jbyte_nxt;
      jcnt_r  <= jcnt_nxt;
      jidx_r  <= jidx_nxt;
      jend_r  <= jend_nxt;
      jbad_r  <= jbad_nxt;
      slot_r  <= slot_nxt;
      part_r  <= part_nxt;
      pend_r  <= pend_nxt;
      lead_r  <= lead_nxt;
      run_r   <= run_nxt;
      lit_r   <= lit_nxt;
      bcnt_r  <= bcnt_nxt;
      fail_r  <= fail_nxt;
      stg_v_r <= stg_v_nxt;
      stg_b_r <= stg_b_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (out_load) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ob_r   <= ld_byte;
      obv_r  <= ld_bv;
      oend_r <= ld_end;
      ost_r  <= ld_st;
    end
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_byte_valid = obv_r;
  assign out_end        = oend_r;
  assign out_status     = ost_r;

endmodule
`default_nettype wire

@@ tb/zero_unit_rle_decompressor_unit_tb.sv @@
`timescale 1ns / 100ps

module zero_unit_rle_decompressor_unit_tb;
  import zurd_pkg::*;

  localparam int MAX_PER_ITEM = 16;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS = 140;

  typedef struct {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic [1:0] stat;
  } dec_byte_t;

  // decoder prediction and result checking
  class decode_scoreboard;
    logic [15:0] cap_bytes;
    logic [7:0]  held_code;
    logic        held_ok;
    logic        pair_open;
    logic [1:0]  pair_first;
    logic [7:0]  pack_byte;
    logic [1:0]  pack_slot;
    logic [15:0] emitted;
    logic        overflowed;
    int          step_results;
    int          errors;
    dec_byte_t   pending_bytes[$];

    function new();
      cap_bytes = MAX_BYTES_RST;
      errors    = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      held_code  = '0;
      held_ok    = 1'b0;
      pair_open  = 1'b0;
      pair_first = '0;
      pack_byte  = '0;
      pack_slot  = '0;
      emitted    = '0;
      overflowed = 1'b0;
    endfunction

    function void set_cap(logic [15:0] cap);
      cap_bytes = cap;
    endfunction

    function int outstanding();
      return pending_bytes.size();
    endfunction

    function void push_result(logic [7:0] d, logic v, logic e, logic [1:0] s);
      dec_byte_t r;
      if (step_results >= MAX_PER_ITEM) return;
      r.data  = d;
      r.valid = v;
      r.last  = e;
      r.stat  = s;
      pending_bytes.push_back(r);
      step_results++;
    endfunction

    // a full byte of units goes out unless the stream already overflowed or has reached the byte limit
    function void finish_byte();
      if (!overflowed) begin
        if (emitted >= cap_bytes) begin
          overflowed = 1'b1;
        end else begin
          push_result(pack_byte, 1'b1, 1'b0, STAT_OK);
          emitted = emitted + 16'd1;
        end
      end
      pack_byte = '0;
      pack_slot = '0;
    endfunction

    function void put_unit(logic [1:0] u);
      pack_byte = pack_byte | ({6'b0, u} << {pack_slot, 1'b0});
      pack_slot = pack_slot + 2'd1;
      if (pack_slot == 2'd0) finish_byte();
    endfunction

    function void put_run(int n, logic [1:0] lo, logic [1:0] hi);
      for (int k = 0; k < n; k++) put_unit((k % 2) ? hi : lo);
    endfunction

    function void expand_code(logic [3:0] nib);
      logic [1:0] kind;
      logic [1:0] arg;
      kind = nib[1:0];
      arg  = nib[3:2];
      if (pair_open) begin
        pair_open = 1'b0;
        // zero lead followed by an all-zero pair is the long zero run
        if (pair_first == 2'd0 && kind == 2'd0 && arg == 2'd0)
          put_run(int'(LONG_RUN), 2'd0, 2'd0);
        else
          put_run(2, kind, arg);
        return;
      end
      case (kind)
        CODE_SHORT: put_run(int'(arg) + int'(SHORT_BASE), 2'd0, 2'd0);
        CODE_MID:   put_run(int'(arg) + int'(MID_BASE), 2'd0, 2'd0);
        CODE_PAIR: begin
          pair_open  = 1'b1;
          pair_first = arg;
          put_unit(arg);
        end
        default:    put_unit(arg);
      endcase
    endfunction

    // works out the results caused by one accepted input transfer
    function void accept_item(logic [7:0] b, logic trailer);
      logic [1:0] end_stat;
      step_results = 0;
      if (!trailer) begin
        if (held_ok) begin
          expand_code(held_code[3:0]);
          expand_code(held_code[7:4]);
        end
        held_code = b;
        held_ok   = 1'b1;
        return;
      end
      if (b != TRAILER_HALF && b != TRAILER_FULL) begin
        push_result(8'h00, 1'b0, 1'b1, STAT_BAD_TRAILER);
        clear_stream();
        return;
      end
      if (held_ok) begin
        expand_code(held_code[3:0]);
        if (b == TRAILER_FULL) expand_code(held_code[7:4]);
      end
      if (pack_slot != 2'd0) finish_byte();
      end_stat = overflowed ? STAT_OVERFLOW : STAT_OK;
      if (step_results == 0 || end_stat != STAT_OK)
        push_result(8'h00, 1'b0, 1'b1, end_stat);
      else
        pending_bytes[pending_bytes.size()-1].last = 1'b1;
      clear_stream();
    endfunction

    task mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_byte(logic [7:0] d, logic [2:0] user, logic last);
      dec_byte_t want;
      if (pending_bytes.size() == 0) begin
        mismatch($sformatf("unexpected result data %02h user %0h last %0b", d, user, last));
        return;
      end
      want = pending_bytes.pop_front();
      if (d !== want.data)
        mismatch($sformatf("out_byte got %02h want %02h", d, want.data));
      if (user[0] !== want.valid)
        mismatch($sformatf("byte_valid got %0b want %0b", user[0], want.valid));
      if (user[2:1] !== want.stat)
        mismatch($sformatf("status got %0d want %0d", user[2:1], want.stat));
      if (last !== want.last)
        mismatch($sformatf("end_of_stream got %0b want %0b", last, want.last));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;   // [7:0] in_byte
  logic                  in_tlast   = 1'b0; // is_trailer
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // [7:0] out_byte
  logic [2:0]            out_tuser;         // [0] byte_valid, [2:1] status
  logic                  out_tlast;         // end_of_stream
  logic                  psel       = 1'b0;
  logic                  penable    = 1'b0;
  logic                  pwrite     = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr      = '0;
  logic [31:0]           pwdata     = '0;
  logic [31:0]           prdata;
  logic                  pready;

  logic steady = 1'b0;
  int   items_sent = 0;
  decode_scoreboard sb = new();

  zero_unit_rle_decompressor_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random back-pressure on the result side
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 29);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tuser, out_tlast);
  end

  // one input transfer, with random gaps ahead of it
  task send_item(logic [7:0] b, logic trailer);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= trailer;
    do @(posedge clk); while (!in_tready);
    sb.accept_item(b, trailer);
    items_sent++;
  endtask

  // hold off input until every expected result is out and the block has settled
  task wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read back
  task cfg_set(logic [15:0] cap);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_MAX_BYTES;
    pwdata  <= {16'b0, cap};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_cap(cap);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== cap)
      sb.mismatch($sformatf("max_output_bytes read %04h want %04h", prdata[15:0], cap));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // code bytes biased toward long runs and pairs spanning two bytes
  function logic [7:0] pick_code_byte();
    case ($urandom_range(11))
      0:       return 8'h01;
      1:       return 8'h10;
      2:       return 8'h00;
      3:       return {4'h0, 2'($urandom_range(3)), CODE_PAIR};
      4:       return TRAILER_HALF;
      5:       return TRAILER_FULL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task send_stream(int n_data);
    logic [7:0] t;
    int         pick;
    for (int k = 0; k < n_data; k++) send_item(pick_code_byte(), 1'b0);
    pick = $urandom_range(9);
    if (pick == 0) begin
      do t = 8'($urandom_range(255)); while (t == TRAILER_HALF || t == TRAILER_FULL);
    end else begin
      t = (pick <= 5) ? TRAILER_FULL : TRAILER_HALF;
    end
    send_item(t, 1'b1);
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [15:0] caps[8];
    int          start_items;
    int          phase;
    int          n;
    caps = '{16'd1, 16'd2, 16'd5, 16'hFFFF, 16'd17, 16'd3, 16'd0, 16'hFFFF};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every code kind, long run inside and across bytes, both trailers
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h21, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h10, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h6A, 1'b0);
    send_item(TRAILER_FULL, 1'b1);
    // trailer with nothing held
    send_item(TRAILER_HALF, 1'b1);
    send_item(8'h35, 1'b0);
    send_item(TRAILER_HALF, 1'b1);
    // bad trailers, with and without a held byte
    send_item(8'h12, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    wait_idle();
    // overflow at a limit of one byte, alone and with a bad trailer
    cfg_set(16'd1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(TRAILER_FULL, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h55, 1'b1);
    send_item(8'h5D, 1'b0);
    send_item(TRAILER_HALF, 1'b1);
    wait_idle();
    cfg_set(16'hFFFF);

    // random streams, limit changed between phases
    start_items = items_sent;
    phase = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      steady = (phase == 1);
      for (int s = 0; s < 5; s++) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 7);
        send_stream(n);
      end
      wait_idle();
      phase++;
      if (caps[phase % 8] == 16'd0)
        cfg_set(16'($urandom_range(1, 65535)));
      else
        cfg_set(caps[phase % 8]);
    end
    steady = 1'b0;

    wait_idle();
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/zurd_pkg.sv
hw/rtl/zurd_front.sv
hw/rtl/zurd_jobq.sv
hw/rtl/zurd_back.sv
hw/rtl/zero_unit_rle_decompressor_unit.sv
tb/zero_unit_rle_decompressor_unit_tb.sv
